// ----- rtl/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, character constants and the alphabet lookup for the Base64
// decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Character codes of the alphabet boundaries and specials
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    // Sextet values at the start of each alphabet range
    localparam logic [7:0] IDX_LOWER = 8'd26;
    localparam logic [7:0] IDX_DIGIT = 8'd52;
    localparam logic [5:0] IDX_PLUS  = 6'd62;
    localparam logic [5:0] IDX_SLASH = 6'd63;

    // Input kind carried on tuser
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // One group of results caused by a single input transfer
    typedef struct packed {
        logic [23:0] word;     // bytes, first byte in the top bits
        logic [1:0]  num;      // number of results, 1 to 3
        logic        data_ok;  // results carry decoded bytes
        logic        msg_end;  // caused by end of text
    } t_grp;

    // Map a character to {invalid, sextet}
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'd0;
        r = 7'b100_0000;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            d = ch - CH_UPPER_A;
            r = {1'b0, d[5:0]};
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            d = ch - CH_LOWER_A + IDX_LOWER;
            r = {1'b0, d[5:0]};
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            d = ch - CH_DIGIT_0 + IDX_DIGIT;
            r = {1'b0, d[5:0]};
        end else if (ch == CH_PLUS) begin
            r = {1'b0, IDX_PLUS};
        end else if (ch == CH_SLASH) begin
            r = {1'b0, IDX_SLASH};
        end
        return r;
    endfunction

endpackage

// ----- rtl/base64_decoder_core.sv -----
// ----------------------------------------------------------------------------
// base64_decoder_core
// Streaming Base64 decoder: one text character per transfer in, decoded
// bytes out.
// ----------------------------------------------------------------------------
// The block takes one character per cycle on the slave stream (tuser 0) or
// an end-of-text mark (tuser 1). Characters outside the standard alphabet
// are skipped and produce nothing; '=' counts as padding. The fourth
// character of a quad releases up to three bytes, and end of text flushes a
// partial quad, or sends one transfer with tuser[0] low if it held fewer
// than two sextets. Every character is held in the input register, where
// it is decoded against the quad state. Its group moves into the result
// register once that register is free, and the first byte is offered from
// there. The bytes then leave one per cycle while the sink is ready. Input
// stalls only when a new group is ready while the result register still
// holds bytes not yet taken.
module base64_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  logic       s_axis_tuser,   // [0] action
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] message_end
    output logic       m_axis_tlast    // last_of_run
);

    logic           slot_free;
    logic           push;
    b64d_pkg::t_grp grp;

    // Decode characters and track the quad
    b64d_unpack u_unpack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_slot_free (slot_free),
        .o_push      (push),
        .o_grp       (grp)
    );

    // Send each group one byte per transfer
    b64d_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_grp    (grp),
        .o_free   (slot_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ----- rtl/b64d_unpack.sv -----
// ----------------------------------------------------------------------------
// b64d_unpack
// Input register, quad state and character decode; hands a group of up to
// three results to the output stage.
// ----------------------------------------------------------------------------
module b64d_unpack (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tvalid,
    output logic            o_tready,
    input  logic [7:0]      i_tdata,     // [7:0] symbol
    input  logic            i_tuser,     // [0] action
    input  logic            i_slot_free,
    output logic            o_push,
    output b64d_pkg::t_grp  o_grp
);

    logic             r_in_valid;
    logic             r_in_act;
    logic [7:0]       r_in_sym;
    logic [5:0]       r_store [3];
    logic [1:0]       r_fill;
    logic [1:0]       r_pad;

    logic [6:0]       code;
    logic             is_pad;
    logic             skip;
    logic [5:0]       v;
    logic [2:0]       pads_sum;
    logic [2:0]       used;
    logic [2:0]       nbytes;
    logic             has_res;
    logic             do_clear;
    logic             do_store;
    logic             consume;
    b64d_pkg::t_grp   grp;

    // Decode the registered character against the quad state
    always_comb begin
        code     = b64d_pkg::sextet_of(r_in_sym);
        is_pad   = (r_in_sym == b64d_pkg::CH_PAD);
        skip     = !is_pad && code[6];
        v        = is_pad ? 6'd0 : code[5:0];
        pads_sum = {1'b0, r_pad} + {2'b00, is_pad};
        used     = 3'd4 - pads_sum;
        nbytes   = used - 3'd1;
        has_res  = 1'b0;
        do_clear = 1'b0;
        do_store = 1'b0;
        grp      = '0;
        if (r_in_act == b64d_pkg::ACT_END) begin
            has_res     = 1'b1;
            do_clear    = 1'b1;
            grp.msg_end = 1'b1;
            if (r_fill >= 2'd2) begin
                grp.num     = r_fill - 2'd1;
                grp.data_ok = 1'b1;
                grp.word    = {r_store[0], r_store[1],
                               (r_fill == 2'd3) ? r_store[2] : 6'd0, 6'd0};
            end else begin
                grp.num = 2'd1;
            end
        end else if (skip) begin
            has_res = 1'b0;
        end else if (r_fill != 2'd3) begin
            do_store = 1'b1;
        end else begin
            do_clear = 1'b1;
            if (used >= 3'd2) begin
                has_res     = 1'b1;
                grp.num     = nbytes[1:0];
                grp.data_ok = 1'b1;
                grp.word    = {r_store[0], r_store[1],
                               (used > 3'd2) ? r_store[2] : 6'd0,
                               (used > 3'd3) ? v : 6'd0};
            end
        end
    end

    // Retire the held item when its results have somewhere to go
    assign consume  = r_in_valid && (!has_res || i_slot_free);
    assign o_push   = r_in_valid && has_res && i_slot_free;
    assign o_grp    = grp;
    assign o_tready = !r_in_valid || consume;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_tready) begin
            r_in_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_in_act <= i_tuser;
            r_in_sym <= i_tdata;
        end
    end

    // Quad state: store a sextet or clear after a quad or end of text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store[0] <= 6'd0;
            r_store[1] <= 6'd0;
            r_store[2] <= 6'd0;
            r_fill     <= 2'd0;
            r_pad      <= 2'd0;
        end else if (consume && do_clear) begin
            r_store[0] <= 6'd0;
            r_store[1] <= 6'd0;
            r_store[2] <= 6'd0;
            r_fill     <= 2'd0;
            r_pad      <= 2'd0;
        end else if (consume && do_store) begin
            r_store[r_fill] <= v;
            r_fill          <= r_fill + 2'd1;
            r_pad           <= pads_sum[1:0];
        end
    end

    // Padding never outnumbers the sextets held
    a_pad_le_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad <= r_fill)
        else $error("pad count exceeds fill count");

    // End of text leaves an empty quad
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in_act == b64d_pkg::ACT_END) |=> (r_fill == 2'd0 && r_pad == 2'd0))
        else $error("quad not cleared after end of text");

    // A held item with results waits until the output slot frees
    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && has_res && !i_slot_free) |=> (r_in_valid && $stable(r_in_sym)))
        else $error("item dropped while output slot busy");

endmodule

// ----- rtl/b64d_emit.sv -----
// ----------------------------------------------------------------------------
// b64d_emit
// Result register that holds one group and sends its bytes one transfer at
// a time.
// ----------------------------------------------------------------------------
module b64d_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64d_pkg::t_grp  i_grp,
    output logic            o_free,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [7:0]      o_tdata,   // [7:0] data_byte
    output logic [1:0]      o_tuser,   // [0] byte_valid, [1] message_end
    output logic            o_tlast    // last_of_run
);

    b64d_pkg::t_grp r_grp;
    logic           r_grp_valid;
    logic [1:0]     r_idx;
    logic           last;

    assign last     = (r_idx == r_grp.num - 2'd1);
    assign o_free   = !r_grp_valid || (i_tready && last);
    assign o_tvalid = r_grp_valid;
    assign o_tlast  = last;
    assign o_tuser  = {r_grp.msg_end, r_grp.data_ok};

    // Select the byte at the current position
    always_comb begin
        case (r_idx)
            2'd0:    o_tdata = r_grp.word[23:16];
            2'd1:    o_tdata = r_grp.word[15:8];
            2'd2:    o_tdata = r_grp.word[7:0];
            default: o_tdata = 8'd0;
        endcase
    end

    // Load a new group or advance through the held one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else if (i_push) begin
            r_grp_valid <= 1'b1;
            r_idx       <= 2'd0;
        end else if (r_grp_valid && i_tready) begin
            if (last) begin
                r_grp_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_grp <= i_grp;
        end
    end

    // Position stays inside the group
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grp_valid |-> (r_idx < r_grp.num))
        else $error("byte position beyond group");

    // A group without bytes is the single end-of-text marker
    a_null_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_grp_valid && !r_grp.data_ok) |-> (r_grp.num == 2'd1 && r_grp.msg_end))
        else $error("empty group that is not an end marker");

    // A group is only replaced once its last byte is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!r_grp_valid || (i_tready && last)))
        else $error("group overwritten before it was sent");

endmodule
